### rtl/core/pvt_pkg.sv
// Shared widths, register codes, reset values and types for the perspective
// vertex transform. No dependencies.
package pvt_pkg;

    localparam int VertW     = 32;
    localparam int CoefW     = 16;
    localparam int ProdW     = VertW + CoefW;
    localparam int SumW      = 50;
    localparam int NumW      = 64;
    localparam int DivW      = 84;
    localparam int QW        = 34;
    localparam int DivSteps  = QW;
    localparam int DivLat    = DivSteps + 1;
    localparam int ResW      = 37;
    localparam int CfgIdxW   = 3;
    localparam int CfgW      = 64;
    localparam int FifoDepth = 2;
    localparam int FifoPtrW  = $clog2(FifoDepth);
    localparam int FifoCntW  = $clog2(FifoDepth + 1);

    localparam logic [CfgIdxW-1:0] RegColX     = 3'd0;
    localparam logic [CfgIdxW-1:0] RegColY     = 3'd1;
    localparam logic [CfgIdxW-1:0] RegColZ     = 3'd2;
    localparam logic [CfgIdxW-1:0] RegColW     = 3'd3;
    localparam logic [CfgIdxW-1:0] RegViewport = 3'd4;

    localparam logic [CfgW-1:0] ColXReset     = 64'd4096;
    localparam logic [CfgW-1:0] ColYReset     = 64'd268435456;
    localparam logic [CfgW-1:0] ColZReset     = 64'd17592186044416;
    localparam logic [CfgW-1:0] ColWReset     = 64'd1152921504606846976;
    localparam logic [CfgW-1:0] ViewportReset = 64'd1048592;

    localparam logic signed [VertW-1:0] S32Max = 32'sh7fffffff;
    localparam logic signed [VertW-1:0] S32Min = 32'sh80000000;

    typedef struct packed {
        logic [CfgW-1:0] col_x;
        logic [CfgW-1:0] col_y;
        logic [CfgW-1:0] col_z;
        logic [CfgW-1:0] col_w;
        logic [CfgW-1:0] viewport;
    } t_cfg;

    typedef struct packed {
        logic signed [NumW-1:0]  num_x;
        logic signed [NumW-1:0]  num_y;
        logic signed [SumW-1:0]  sum_z;
        logic signed [SumW-1:0]  sum_w;
        logic signed [CoefW-1:0] off_x;
        logic signed [CoefW-1:0] off_y;
        logic                    last;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic                    w_zero;
        logic                    z_zero;
        logic                    x_num_neg;
        logic                    y_num_neg;
        logic                    x_neg;
        logic                    y_neg;
        logic                    z_neg;
        logic signed [CoefW-1:0] off_x;
        logic signed [CoefW-1:0] off_y;
        logic                    last;
    } t_side;

    function automatic logic signed [VertW-1:0] sat32(input logic signed [ResW-1:0] v);
        logic signed [VertW-1:0] r;
        if (v > ResW'(S32Max)) begin
            r = S32Max;
        end else if (v < ResW'(S32Min)) begin
            r = S32Min;
        end else begin
            r = v[VertW-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/pvt_front.sv
// Front end: column products, column sums and numerator scaling.
// Depends on pvt_pkg.
module pvt_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic signed [pvt_pkg::VertW-1:0]    i_vert_x,
    input  logic signed [pvt_pkg::VertW-1:0]    i_vert_y,
    input  logic signed [pvt_pkg::VertW-1:0]    i_vert_z,
    input  logic                                i_last,
    input  pvt_pkg::t_cfg                       i_cfg,
    output logic                                o_vld,
    output pvt_pkg::t_work                      o_work
);

    logic [pvt_pkg::CfgW-1:0]           cols [0:3];
    logic signed [pvt_pkg::VertW-1:0]   vin  [0:2];
    logic signed [pvt_pkg::ProdW-1:0]   n1_prod [0:11];
    logic signed [pvt_pkg::ProdW-1:0]   r1_prod [0:11];
    logic signed [pvt_pkg::SumW-1:0]    n2_sum  [0:3];
    logic signed [pvt_pkg::SumW-1:0]    r2_sum  [0:3];
    logic                               r1_vld, r2_vld, r3_vld;
    logic                               r1_last, r2_last, r3_last;
    logic signed [pvt_pkg::NumW-1:0]    r3_num_x, r3_num_y;
    logic signed [pvt_pkg::SumW-1:0]    r3_sum_z, r3_sum_w;
    logic signed [pvt_pkg::CoefW-1:0]   r3_off_x, r3_off_y;
    logic signed [pvt_pkg::CoefW-1:0]   scale_x, scale_y;

    assign cols[0] = i_cfg.col_x;
    assign cols[1] = i_cfg.col_y;
    assign cols[2] = i_cfg.col_z;
    assign cols[3] = i_cfg.col_w;
    assign vin[0]  = i_vert_x;
    assign vin[1]  = i_vert_y;
    assign vin[2]  = i_vert_z;
    assign scale_x = i_cfg.viewport[15:0];
    assign scale_y = i_cfg.viewport[31:16];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 3; r++) begin
                n1_prod[c*3+r] = vin[r] * $signed(cols[c][16*r +: 16]);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n2_sum[c] = pvt_pkg::SumW'(r1_prod[c*3])
                      + pvt_pkg::SumW'(r1_prod[c*3+1])
                      + pvt_pkg::SumW'(r1_prod[c*3+2])
                      + $signed({{(pvt_pkg::SumW-32){cols[c][63]}}, cols[c][63:48], 16'd0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_prod  <= n1_prod;
        r1_last  <= i_last;
        r2_sum   <= n2_sum;
        r2_last  <= r1_last;
        r3_num_x <= r2_sum[0] * scale_x;
        r3_num_y <= r2_sum[1] * scale_y;
        r3_sum_z <= r2_sum[2];
        r3_sum_w <= r2_sum[3];
        r3_off_x <= i_cfg.viewport[47:32];
        r3_off_y <= i_cfg.viewport[63:48];
        r3_last  <= r2_last;
    end

    assign o_vld        = r3_vld;
    assign o_work.num_x = r3_num_x;
    assign o_work.num_y = r3_num_y;
    assign o_work.sum_z = r3_sum_z;
    assign o_work.sum_w = r3_sum_w;
    assign o_work.off_x = r3_off_x;
    assign o_work.off_y = r3_off_y;
    assign o_work.last  = r3_last;

endmodule

### rtl/core/pvt_fifo.sv
// Short item queue between front and back end.
// Depends on pvt_pkg.
module pvt_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pvt_pkg::t_work   i_data,
    input  logic             i_pop,
    output pvt_pkg::t_work   o_data,
    output pvt_pkg::t_q_stat o_stat
);

    pvt_pkg::t_work                r_mem [0:pvt_pkg::FifoDepth-1];
    logic [pvt_pkg::FifoPtrW-1:0]  r_wptr, r_rptr;
    logic [pvt_pkg::FifoCntW-1:0]  r_count;
    logic                          do_push, do_pop;

    assign o_stat.full  = (r_count == pvt_pkg::FifoCntW'(pvt_pkg::FifoDepth));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + pvt_pkg::FifoCntW'(do_push) - pvt_pkg::FifoCntW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

### rtl/core/pvt_div.sv
// Pipelined restoring divider, one quotient bit per stage; top bit flags overflow.
// Depends on pvt_pkg.
module pvt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [pvt_pkg::DivW-1:0]    i_num,
    input  logic [pvt_pkg::SumW-1:0]    i_den,
    output logic                        o_vld,
    output logic [pvt_pkg::QW-1:0]      o_quo
);

    logic [pvt_pkg::DivW-1:0] r_rem [0:pvt_pkg::DivSteps-1];
    logic [pvt_pkg::SumW-1:0] r_den [0:pvt_pkg::DivSteps-1];
    logic [pvt_pkg::QW-1:0]   r_q   [0:pvt_pkg::DivSteps];
    logic                     r_vld [0:pvt_pkg::DivSteps];
    logic [pvt_pkg::DivW-1:0] n_sh  [0:pvt_pkg::DivSteps-1];
    logic                     n_ge  [0:pvt_pkg::DivSteps-1];
    logic [pvt_pkg::DivW-1:0] n_rem [0:pvt_pkg::DivSteps-1];

    always_comb begin
        for (int k = 0; k < pvt_pkg::DivSteps; k++) begin
            n_sh[k]  = pvt_pkg::DivW'(r_den[k]) << (pvt_pkg::DivSteps - 1 - k);
            n_ge[k]  = (r_rem[k] >= n_sh[k]);
            n_rem[k] = n_ge[k] ? (r_rem[k] - n_sh[k]) : r_rem[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= pvt_pkg::DivSteps; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int k = 0; k < pvt_pkg::DivSteps; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        for (int k = 0; k < pvt_pkg::DivSteps - 1; k++) begin
            r_rem[k+1] <= n_rem[k];
            r_den[k+1] <= r_den[k];
        end
        for (int k = 0; k < pvt_pkg::DivSteps; k++) begin
            r_q[k+1] <= {r_q[k][pvt_pkg::QW-2:0], n_ge[k]};
        end
    end

    assign o_vld = r_vld[pvt_pkg::DivSteps];
    assign o_quo = r_q[pvt_pkg::DivSteps];

endmodule

### rtl/core/pvt_back.sv
// Back end: three dividers, sideband delay line, sign, offset and saturation.
// Depends on pvt_pkg and pvt_div.
module pvt_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  pvt_pkg::t_work                    i_work,
    output logic                              o_strobe,
    output logic signed [pvt_pkg::VertW-1:0]  o_screen_x,
    output logic signed [pvt_pkg::VertW-1:0]  o_screen_y,
    output logic signed [pvt_pkg::VertW-1:0]  o_inv_depth,
    output logic                              o_div_fault,
    output logic                              o_last_out
);

    pvt_pkg::t_side              side_in;
    pvt_pkg::t_side              r_side [0:pvt_pkg::DivLat-1];
    pvt_pkg::t_side              s;
    logic [pvt_pkg::NumW-1:0]    mag_x, mag_y;
    logic [pvt_pkg::SumW-1:0]    mag_z, mag_w;
    logic [pvt_pkg::DivW-1:0]    num_x, num_y, num_z;
    logic                        vld_x, vld_y, vld_z;
    logic [pvt_pkg::QW-1:0]      q_x, q_y, q_z;
    logic signed [pvt_pkg::VertW-1:0] n_sx, n_sy, n_dz;
    logic                        r_strobe;
    logic signed [pvt_pkg::VertW-1:0] r_sx, r_sy, r_dz;
    logic                        r_fault, r_last;

    assign mag_x = i_work.num_x[pvt_pkg::NumW-1] ? -i_work.num_x : i_work.num_x;
    assign mag_y = i_work.num_y[pvt_pkg::NumW-1] ? -i_work.num_y : i_work.num_y;
    assign mag_z = i_work.sum_z[pvt_pkg::SumW-1] ? -i_work.sum_z : i_work.sum_z;
    assign mag_w = i_work.sum_w[pvt_pkg::SumW-1] ? -i_work.sum_w : i_work.sum_w;
    assign num_x = pvt_pkg::DivW'(mag_x) << 12;
    assign num_y = pvt_pkg::DivW'(mag_y) << 12;
    assign num_z = pvt_pkg::DivW'(1) << 44;

    assign side_in.w_zero    = (i_work.sum_w == '0);
    assign side_in.z_zero    = (i_work.sum_z == '0);
    assign side_in.x_num_neg = i_work.num_x[pvt_pkg::NumW-1];
    assign side_in.y_num_neg = i_work.num_y[pvt_pkg::NumW-1];
    assign side_in.x_neg     = i_work.num_x[pvt_pkg::NumW-1] ^ i_work.sum_w[pvt_pkg::SumW-1];
    assign side_in.y_neg     = i_work.num_y[pvt_pkg::NumW-1] ^ i_work.sum_w[pvt_pkg::SumW-1];
    assign side_in.z_neg     = i_work.sum_z[pvt_pkg::SumW-1];
    assign side_in.off_x     = i_work.off_x;
    assign side_in.off_y     = i_work.off_y;
    assign side_in.last      = i_work.last;

    pvt_div u_div_x (.i_clk, .i_rst_n, .i_vld(i_vld), .i_num(num_x), .i_den(mag_w),
                     .o_vld(vld_x), .o_quo(q_x));
    pvt_div u_div_y (.i_clk, .i_rst_n, .i_vld(i_vld), .i_num(num_y), .i_den(mag_w),
                     .o_vld(vld_y), .o_quo(q_y));
    pvt_div u_div_z (.i_clk, .i_rst_n, .i_vld(i_vld), .i_num(num_z), .i_den(mag_z),
                     .o_vld(vld_z), .o_quo(q_z));

    always_ff @(posedge i_clk) begin
        r_side[0] <= side_in;
        for (int k = 0; k < pvt_pkg::DivLat - 1; k++) begin
            r_side[k+1] <= r_side[k];
        end
    end

    assign s = r_side[pvt_pkg::DivLat-1];

    always_comb begin
        logic signed [pvt_pkg::ResW-1:0] vx, vy, vz;
        vx = $signed({3'b000, q_x});
        vy = $signed({3'b000, q_y});
        vz = $signed({3'b000, q_z});
        if (s.x_neg) vx = -vx;
        if (s.y_neg) vy = -vy;
        if (s.z_neg) vz = -vz;
        vx = vx + $signed({{9{s.off_x[15]}}, s.off_x, 12'd0});
        vy = vy + $signed({{9{s.off_y[15]}}, s.off_y, 12'd0});

        if (s.w_zero) begin
            n_sx = s.x_num_neg ? pvt_pkg::S32Min : pvt_pkg::S32Max;
            n_sy = s.y_num_neg ? pvt_pkg::S32Min : pvt_pkg::S32Max;
        end else begin
            n_sx = q_x[pvt_pkg::QW-1] ? (s.x_neg ? pvt_pkg::S32Min : pvt_pkg::S32Max)
                                      : pvt_pkg::sat32(vx);
            n_sy = q_y[pvt_pkg::QW-1] ? (s.y_neg ? pvt_pkg::S32Min : pvt_pkg::S32Max)
                                      : pvt_pkg::sat32(vy);
        end
        if (s.z_zero) begin
            n_dz = pvt_pkg::S32Max;
        end else begin
            n_dz = q_z[pvt_pkg::QW-1] ? (s.z_neg ? pvt_pkg::S32Min : pvt_pkg::S32Max)
                                      : pvt_pkg::sat32(vz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= vld_x & vld_y & vld_z;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx    <= n_sx;
        r_sy    <= n_sy;
        r_dz    <= n_dz;
        r_fault <= s.w_zero | s.z_zero;
        r_last  <= s.last;
    end

    assign o_strobe    = r_strobe;
    assign o_screen_x  = r_sx;
    assign o_screen_y  = r_sy;
    assign o_inv_depth = r_dz;
    assign o_div_fault = r_fault;
    assign o_last_out  = r_last;

endmodule

### rtl/core/perspective_vertex_transform.sv
// Perspective vertex transform top level: config registers, front, queue, back.
// Depends on pvt_pkg, pvt_front, pvt_fifo, pvt_back.
// Throughput: one vertex per cycle while busy is low; set by the 34-stage divider pipelines.
// Reset: synchronous, active low; config returns to identity matrix and unit viewport.
// Results cannot be stalled; each stays on the ports for one cycle.
module perspective_vertex_transform (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [pvt_pkg::VertW-1:0]     i_vert_x,
    input  logic signed [pvt_pkg::VertW-1:0]     i_vert_y,
    input  logic signed [pvt_pkg::VertW-1:0]     i_vert_z,
    input  logic                                 i_last_in,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pvt_pkg::CfgIdxW-1:0]          i_cfg_index,
    input  logic [pvt_pkg::CfgW-1:0]             i_cfg_data,
    output logic                                 o_strobe,
    output logic signed [pvt_pkg::VertW-1:0]     o_screen_x,
    output logic signed [pvt_pkg::VertW-1:0]     o_screen_y,
    output logic signed [pvt_pkg::VertW-1:0]     o_inv_depth,
    output logic                                 o_div_fault,
    output logic                                 o_last_out
);

    pvt_pkg::t_cfg    r_cfg;
    pvt_pkg::t_work   w_front_work, w_q_work;
    pvt_pkg::t_q_stat w_q_stat;
    logic             w_front_vld, w_q_pop, w_accept;

    assign o_cfg_ready = 1'b1;
    assign busy        = w_q_stat.full;
    assign w_accept    = start && !busy;
    assign w_q_pop     = !w_q_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.col_x    <= pvt_pkg::ColXReset;
            r_cfg.col_y    <= pvt_pkg::ColYReset;
            r_cfg.col_z    <= pvt_pkg::ColZReset;
            r_cfg.col_w    <= pvt_pkg::ColWReset;
            r_cfg.viewport <= pvt_pkg::ViewportReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pvt_pkg::RegColX:     r_cfg.col_x    <= i_cfg_data;
                pvt_pkg::RegColY:     r_cfg.col_y    <= i_cfg_data;
                pvt_pkg::RegColZ:     r_cfg.col_z    <= i_cfg_data;
                pvt_pkg::RegColW:     r_cfg.col_w    <= i_cfg_data;
                pvt_pkg::RegViewport: r_cfg.viewport <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pvt_front u_front (
        .i_clk, .i_rst_n,
        .i_vld(w_accept), .i_vert_x, .i_vert_y, .i_vert_z, .i_last(i_last_in),
        .i_cfg(r_cfg), .o_vld(w_front_vld), .o_work(w_front_work)
    );

    pvt_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push(w_front_vld), .i_data(w_front_work), .i_pop(w_q_pop),
        .o_data(w_q_work), .o_stat(w_q_stat)
    );

    pvt_back u_back (
        .i_clk, .i_rst_n,
        .i_vld(w_q_pop), .i_work(w_q_work),
        .o_strobe, .o_screen_x, .o_screen_y, .o_inv_depth, .o_div_fault, .o_last_out
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_front_vld && w_q_stat.full))
        else $error("item pushed into full queue");

    a_strobe_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_q_pop, pvt_pkg::DivLat + 1))
        else $error("result without matching queue pop");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe after reset");

endmodule
